// ===== rtl/mpfe_pkg.sv =====
// shared types and constants for the page framebuffer engine
package mpfe_pkg;

  localparam int Width = 128;
  localparam int Height = 64;
  localparam int Pages = Height / 8;
  localparam int Rows = Pages * 8;
  localparam int Depth = Width * Pages;
  localparam int AddrW = $clog2(Depth);
  localparam int ColW = $clog2(Width + 1);
  localparam int PageW = (Pages > 1) ? $clog2(Pages) : 1;
  localparam int PosW = $clog2(Width + 3);
  localparam int RowW = $clog2(Rows + 1);

  typedef enum logic [2:0] {
    ActPixel   = 3'd0,
    ActOutline = 3'd1,
    ActFill    = 3'd2,
    ActClear   = 3'd3,
    ActCls     = 3'd4,
    ActFlush   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    StDone     = 2'd0,
    StFlushB   = 2'd1,
    StNothing  = 2'd2,
    StRejected = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    SInit, SIdle, SSweepRd, SSweepWb, SRectRd, SRectWb, SFlushRd, SFlushOut, SOut
  } state_e;

  localparam logic [7:0] CmdPage = 8'hB0;
  localparam logic [7:0] CmdLow  = 8'h00;
  localparam logic [7:0] CmdHigh = 8'h10;

  typedef struct packed {
    logic           sweep_start;
    logic           rect_load;
    logic [1:0]     rect_pass;
    logic           rect_on;
    logic           rect_pix;
    logic           rect_line;
    logic           rd;
    logic           flush_rd;
    logic           wb;
    logic           step;
    logic           init_step;
  } dp_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic rect_empty;
    logic init_last;
  } dp_sts_t;

endpackage

// ===== rtl/mpfe_ram.sv =====
// generic single port ram with registered read
module mpfe_ram #(
  parameter int DataW = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [DataW-1:0]         wdata_i,
  output logic [DataW-1:0]         rdata_o
);
  logic [DataW-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== rtl/mpfe_datapath.sv =====
// rectangle walker, pixel merge and frame memory
module mpfe_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  mpfe_pkg::dp_cmd_t          cmd_i,
  input  logic signed [10:0]         x_i,
  input  logic signed [10:0]         y_i,
  input  logic signed [10:0]         w_i,
  input  logic signed [10:0]         h_i,
  input  logic [mpfe_pkg::PageW-1:0] fpage_i,
  input  logic [mpfe_pkg::PosW-1:0]  fpos_i,
  output mpfe_pkg::dp_sts_t          sts_o,
  output logic [7:0]                 rdata_o,
  output logic                       changed_o,
  output logic [mpfe_pkg::PageW-1:0] cur_page_o
);
  localparam int AW = mpfe_pkg::AddrW;
  localparam int CW = mpfe_pkg::ColW;
  localparam int RW = mpfe_pkg::RowW;

  logic [CW-1:0] x0_q, x1_q, cx_q, x0_d, x1_d;
  logic [RW-1:0] y0_q, y1_q, cy_q, y0_d, y1_d;
  logic signed [10:0] gx_q, gy_q, gw_q, gh_q;
  logic signed [10:0] sx, sy, sw, sh;
  logic on_q;
  logic [AW-1:0] init_q;
  logic [AW-1:0] addr;
  logic [7:0] mask, nw;
  logic we;

  function automatic logic [12:0] clampv(input logic signed [12:0] v, input int hi);
    if (v < 0) return 13'd0;
    if (v > 13'(hi)) return 13'(hi);
    return v;
  endfunction

  // geometry of the beat, kept for the later outline passes
  always_ff @(posedge clk_i) begin
    if (cmd_i.rect_load && cmd_i.rect_pass == 2'd0) begin
      gx_q <= x_i; gy_q <= y_i; gw_q <= w_i; gh_q <= h_i;
    end
  end

  assign sx = (cmd_i.rect_pass == 2'd0) ? x_i : gx_q;
  assign sy = (cmd_i.rect_pass == 2'd0) ? y_i : gy_q;
  assign sw = (cmd_i.rect_pass == 2'd0) ? w_i : gw_q;
  assign sh = (cmd_i.rect_pass == 2'd0) ? h_i : gh_q;

  // pass 0 full rect, single pixel or top edge; 1 bottom, 2 left, 3 right edge
  always_comb begin
    logic signed [12:0] xs, ys, xe, ye;
    xs = 13'(sx);
    ys = 13'(sy);
    xe = 13'(sx) + 13'(sw);
    ye = 13'(sy) + 13'(sh);
    case (cmd_i.rect_pass)
      2'd1: begin ys = ye - 13'sd1; end
      2'd2: begin xe = xs + 13'sd1; end
      2'd3: begin xs = xe - 13'sd1; end
      default: begin
        if (cmd_i.rect_pix) begin
          xe = xs + 13'sd1;
          ye = ys + 13'sd1;
        end else if (cmd_i.rect_line) begin
          ye = ys + 13'sd1;
        end
      end
    endcase
    x0_d = CW'(clampv(xs, mpfe_pkg::Width));
    x1_d = CW'(clampv(xe, mpfe_pkg::Width));
    y0_d = RW'(clampv(ys, mpfe_pkg::Rows));
    y1_d = RW'(clampv(ye, mpfe_pkg::Rows));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q <= '0;
    end else if (cmd_i.init_step) begin
      init_q <= init_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.rect_load) begin
      x0_q <= x0_d; x1_q <= x1_d; y0_q <= y0_d; y1_q <= y1_d;
      cx_q <= x0_d; cy_q <= y0_d; on_q <= cmd_i.rect_on;
    end else if (cmd_i.sweep_start) begin
      cx_q <= '0; cy_q <= '0;
      x1_q <= CW'(mpfe_pkg::Width); y1_q <= RW'(mpfe_pkg::Rows); x0_q <= '0;
      on_q <= 1'b0;
    end else if (cmd_i.step) begin
      if (cx_q + 1'b1 >= x1_q) begin
        cx_q <= x0_q; cy_q <= cy_q + 1'b1;
      end else begin
        cx_q <= cx_q + 1'b1;
      end
    end
  end

  assign sts_o.rect_empty = (x0_q >= x1_q) || (y0_q >= y1_q);
  assign sts_o.sweep_last = (cx_q + 1'b1 >= x1_q) && (cy_q + 1'b1 >= y1_q);
  assign sts_o.init_last = (init_q == AW'(mpfe_pkg::Depth - 1));

  assign cur_page_o = mpfe_pkg::PageW'(cy_q >> 3);
  assign mask = 8'(1) << cy_q[2:0];
  assign nw = on_q ? (rdata_o | mask) : (rdata_o & ~mask);
  assign changed_o = (nw != rdata_o);

  always_comb begin
    if (cmd_i.init_step) addr = init_q;
    else if (cmd_i.rd && cmd_i.flush_rd)
      addr = AW'(32'(fpage_i) * mpfe_pkg::Width + 32'(fpos_i) - 32'd3);
    else addr = AW'(32'(cy_q >> 3) * mpfe_pkg::Width + 32'(cx_q));
  end
  assign we = cmd_i.init_step || (cmd_i.wb && changed_o);

  mpfe_ram #(.DataW(8), .Depth(mpfe_pkg::Depth)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(cmd_i.init_step ? 8'h00 : nw),
    .rdata_o(rdata_o)
  );
endmodule

// ===== rtl/mpfe_ctrl.sv =====
// controller for drawing, clearing and flushing
module mpfe_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [2:0]                 action_i,
  input  logic                       pixel_on_i,
  input  logic signed [10:0]         w_i,
  input  logic signed [10:0]         h_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [1:0]                 status_o,
  output logic [7:0]                 out_byte_o,
  output logic                       is_data_o,
  output logic                       flush_last_o,
  output logic [7:0]                 dirty_mask_o,
  output mpfe_pkg::dp_cmd_t          cmd_o,
  input  mpfe_pkg::dp_sts_t          sts_i,
  input  logic [7:0]                 rdata_i,
  input  logic                       changed_i,
  input  logic [mpfe_pkg::PageW-1:0] cur_page_i,
  output logic [mpfe_pkg::PageW-1:0] fpage_o,
  output logic [mpfe_pkg::PosW-1:0]  fpos_o
);
  localparam int PW = mpfe_pkg::PageW;
  localparam int NP = mpfe_pkg::Pages;
  localparam logic [7:0] AllPages = 8'((9'd1 << NP) - 9'd1);

  mpfe_pkg::state_e state_q, state_d;
  logic [7:0] dirty_q, dirty_d;
  logic fact_q, fact_d;
  logic [PW-1:0] fpage_q, fpage_d;
  logic [mpfe_pkg::PosW-1:0] fpos_q, fpos_d;
  logic [1:0] pass_q, pass_d;
  logic [2:0] act_q, act_d;
  logic on_q, on_d;
  logic [1:0] st_q, st_d;
  logic [7:0] byte_q, byte_d;
  logic isd_q, isd_d, last_q, last_d;
  logic [PW:0] nd_first, nd_next;
  logic ok_wh;

  always_comb begin
    nd_first = (PW+1)'(NP);
    for (int p = NP - 1; p >= 0; p--) if (dirty_q[p]) nd_first = (PW+1)'(p);
    nd_next = (PW+1)'(NP);
    for (int p = NP - 1; p >= 0; p--)
      if (dirty_q[p] && p > int'(fpage_q)) nd_next = (PW+1)'(p);
  end

  assign ok_wh = (w_i > 0) && (h_i > 0);
  assign fpage_o = fpage_q;
  assign fpos_o = fpos_q;
  assign dirty_mask_o = dirty_q;
  assign status_o = st_q;
  assign out_byte_o = byte_q;
  assign is_data_o = isd_q;
  assign flush_last_o = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mpfe_pkg::SInit;
      dirty_q <= '0; fact_q <= 1'b0; fpage_q <= '0; fpos_q <= '0;
      pass_q <= '0; act_q <= '0; on_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dirty_q <= dirty_d; fact_q <= fact_d; fpage_q <= fpage_d; fpos_q <= fpos_d;
      pass_q <= pass_d; act_q <= act_d; on_q <= on_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d; byte_q <= byte_d; isd_q <= isd_d; last_q <= last_d;
  end

  always_comb begin
    state_d = state_q;
    dirty_d = dirty_q; fact_d = fact_q; fpage_d = fpage_q; fpos_d = fpos_q;
    pass_d = pass_q; act_d = act_q; on_d = on_q;
    st_d = st_q; byte_d = byte_q; isd_d = isd_q; last_d = last_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      mpfe_pkg::SInit: begin
        cmd_o.init_step = 1'b1;
        if (sts_i.init_last) state_d = mpfe_pkg::SIdle;
      end
      mpfe_pkg::SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          st_d = mpfe_pkg::StDone; byte_d = '0; isd_d = 1'b0; last_d = 1'b0;
          act_d = action_i; on_d = pixel_on_i; pass_d = '0;
          state_d = mpfe_pkg::SOut;
          if (action_i == mpfe_pkg::ActFlush) begin
            if (!fact_q && nd_first == (PW+1)'(NP)) begin
              st_d = mpfe_pkg::StNothing;
            end else begin
              if (!fact_q) begin
                fact_d = 1'b1; fpage_d = PW'(nd_first); fpos_d = '0;
              end
              state_d = mpfe_pkg::SFlushRd;
            end
          end else if (fact_q) begin
            st_d = mpfe_pkg::StRejected;
          end else begin
            case (action_i)
              mpfe_pkg::ActPixel: begin
                cmd_o.rect_load = 1'b1; cmd_o.rect_on = pixel_on_i;
                cmd_o.rect_pix = 1'b1;
                state_d = mpfe_pkg::SRectRd;
              end
              mpfe_pkg::ActOutline, mpfe_pkg::ActFill, mpfe_pkg::ActClear: begin
                if (ok_wh) begin
                  cmd_o.rect_load = 1'b1;
                  cmd_o.rect_on = (action_i != mpfe_pkg::ActClear);
                  cmd_o.rect_line = (action_i == mpfe_pkg::ActOutline);
                  state_d = mpfe_pkg::SRectRd;
                end
              end
              mpfe_pkg::ActCls: begin
                cmd_o.sweep_start = 1'b1;
                dirty_d = AllPages;
                state_d = mpfe_pkg::SSweepRd;
              end
              default: ;
            endcase
          end
        end
      end
      mpfe_pkg::SRectRd: begin
        if (sts_i.rect_empty) begin
          state_d = mpfe_pkg::SSweepWb;
        end else begin
          cmd_o.rd = 1'b1;
          state_d = mpfe_pkg::SRectWb;
        end
      end
      mpfe_pkg::SSweepRd: begin
        cmd_o.rd = 1'b1;
        state_d = mpfe_pkg::SRectWb;
      end
      mpfe_pkg::SRectWb: begin
        cmd_o.wb = 1'b1;
        if (changed_i && act_q != mpfe_pkg::ActCls)
          dirty_d = dirty_q | (8'd1 << cur_page_i);
        if (sts_i.sweep_last) begin
          state_d = mpfe_pkg::SSweepWb;
        end else begin
          cmd_o.step = 1'b1;
          state_d = (act_q == mpfe_pkg::ActCls) ? mpfe_pkg::SSweepRd : mpfe_pkg::SRectRd;
        end
      end
      mpfe_pkg::SSweepWb: begin
        // next outline pass or done
        if (act_q == mpfe_pkg::ActOutline && pass_q != 2'd3) begin
          pass_d = pass_q + 2'd1;
          cmd_o.rect_load = 1'b1; cmd_o.rect_on = 1'b1; cmd_o.rect_line = 1'b1;
          cmd_o.rect_pass = pass_q + 2'd1;
          state_d = mpfe_pkg::SRectRd;
        end else begin
          state_d = mpfe_pkg::SOut;
        end
      end
      mpfe_pkg::SFlushRd: begin
        cmd_o.rd = 1'b1; cmd_o.flush_rd = 1'b1;
        state_d = mpfe_pkg::SFlushOut;
      end
      mpfe_pkg::SFlushOut: begin
        st_d = mpfe_pkg::StFlushB;
        if (fpos_q == '0) byte_d = mpfe_pkg::CmdPage + 8'(fpage_q);
        else if (fpos_q == mpfe_pkg::PosW'(1)) byte_d = mpfe_pkg::CmdLow;
        else if (fpos_q == mpfe_pkg::PosW'(2)) byte_d = mpfe_pkg::CmdHigh;
        else begin byte_d = rdata_i; isd_d = 1'b1; end
        if (fpos_q >= mpfe_pkg::PosW'(mpfe_pkg::Width + 2)) begin
          fpos_d = '0;
          if (nd_next == (PW+1)'(NP)) begin
            last_d = 1'b1; dirty_d = '0; fact_d = 1'b0; fpage_d = '0;
          end else begin
            fpage_d = PW'(nd_next);
          end
        end else begin
          fpos_d = fpos_q + 1'b1;
        end
        state_d = mpfe_pkg::SOut;
      end
      mpfe_pkg::SOut: begin
        out_valid_o = 1'b1;
        if (out_ready_i) state_d = mpfe_pkg::SIdle;
      end
      default: state_d = mpfe_pkg::SIdle;
    endcase
  end
endmodule

// ===== rtl/mono_page_framebuffer_engine.sv =====
// top level of the monochrome page framebuffer engine
//
// one input beat (action and geometry) gives exactly one output beat
// on the valid/ready result channel. beats are handled one at a time.
// drawing reads and writes back the frame memory once for each pixel of the
// clipped area of a pixel, a fill or clear rectangle, or the whole frame for
// clear screen; an outline takes four such passes, one per edge. a rectangle
// of zero or negative size writes nothing, and a flush step gives one byte.
// each dirty page is sent as three command beats and WIDTH data beats.
// after a result is taken the controller returns to idle before the next
// input beat is accepted. drawing speed is set by the single-port frame
// memory doing one read-modify-write per pixel.
// after reset the frame memory is cleared in a pass over all WIDTH * HEIGHT/8
// bytes (1024 at the default size) during which no beat is accepted.
// a result waits in its output register while the receiver stalls; no new
// input beat is taken until it has been delivered.
module mono_page_framebuffer_engine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         action_i,
  input  logic signed [10:0] x_i,
  input  logic signed [10:0] y_i,
  input  logic signed [10:0] width_i,
  input  logic signed [10:0] height_i,
  input  logic               pixel_on_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [7:0]         out_byte_o,
  output logic               is_data_o,
  output logic               flush_last_o,
  output logic [7:0]         dirty_mask_o
);
  mpfe_pkg::dp_cmd_t cmd, cmd_dp;
  mpfe_pkg::dp_sts_t sts;
  logic [7:0] rdata;
  logic changed;
  logic [mpfe_pkg::PageW-1:0] cur_page, fpage;
  logic [mpfe_pkg::PosW-1:0] fpos;

  mpfe_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .action_i, .pixel_on_i,
    .w_i(width_i), .h_i(height_i), .out_valid_o, .out_ready_i,
    .status_o, .out_byte_o, .is_data_o, .flush_last_o, .dirty_mask_o,
    .cmd_o(cmd), .sts_i(sts), .rdata_i(rdata), .changed_i(changed),
    .cur_page_i(cur_page), .fpage_o(fpage), .fpos_o(fpos)
  );

  always_comb begin
    cmd_dp = cmd;
    cmd_dp.sweep_start = cmd.sweep_start;
  end

  mpfe_datapath u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd_dp), .x_i, .y_i, .w_i(width_i), .h_i(height_i),
    .fpage_i(fpage), .fpos_i(fpos), .sts_o(sts), .rdata_o(rdata),
    .changed_o(changed), .cur_page_o(cur_page)
  );
endmodule
